// ----- hdl/ipv4fp_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4fp_pkg
// Shared constants, error codes and the job record passed from the
// classifying front end to the fragment sequencer.
// ----------------------------------------------------------------------------
package ipv4fp_pkg;

  localparam int MAX_FRAGMENTS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam logic [15:0] IP4_HDR_LEN = 16'd20;
  localparam logic [16:0] IP6_HDR_LEN = 17'd40;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MALFORMED = 3'd1;
  localparam logic [2:0] ERR_HEADER    = 3'd2;
  localparam logic [2:0] ERR_DONT_FRAG = 3'd3;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd4;

  localparam logic [1:0] ENCAP_NONE = 2'd0;
  localparam logic [1:0] ENCAP_IPV4 = 2'd1;
  localparam logic [1:0] ENCAP_IPV6 = 2'd2;

  typedef struct packed {
    logic [2:0]  err;
    logic [15:0] id;
    logic [12:0] base_off;
    logic        base_more;
    logic [15:0] rem;
    logic [15:0] chunk;
    logic [9:0]  hoff;
    logic [1:0]  kind;
  } job_t;

endpackage

// ----- hdl/ipv4fp_front.sv -----
// ----------------------------------------------------------------------------
// ipv4fp_front
// Holds one packet request, checks it and computes its fragment plan.
// ----------------------------------------------------------------------------
module ipv4fp_front #(
  parameter int MAX_FRAGMENTS = ipv4fp_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_ip_total_length,
  input  logic [15:0]        in_captured_length,
  input  logic [9:0]         in_header_offset,
  input  logic [15:0]        in_mtu,
  input  logic               in_dont_fragment,
  input  logic               in_more_fragments_in,
  input  logic [12:0]        in_fragment_offset_in,
  input  logic [15:0]        in_ident,
  input  logic [1:0]         in_encap_kind,
  input  logic               q_full,
  output logic               q_push,
  output ipv4fp_pkg::job_t   q_job
);
  import ipv4fp_pkg::*;

  localparam int FW = $clog2(MAX_FRAGMENTS + 1);

  logic        item_valid_r, item_valid_nxt;
  logic [15:0] next_id_r, next_id_nxt;
  logic [15:0] tot_r, capt_r, mtu_r, id_in_r;
  logic [9:0]  hoff_r;
  logic        df_r, mf_r;
  logic [12:0] off_r;
  logic [1:0]  kind_r;

  logic             in_accept;
  logic             malformed, mtu_small, nonfrag, id_adv, fits, room_small, too_many;
  logic [15:0]      rem;
  logic signed [17:0] room;
  logic [15:0]      chunk;
  logic [15+FW:0]   limit;

  assign q_push    = item_valid_r & ~q_full;
  assign in_stall  = item_valid_r & ~q_push;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    malformed = (tot_r < IP4_HDR_LEN) || (capt_r < IP4_HDR_LEN) || (tot_r < capt_r);
    mtu_small = mtu_r < IP4_HDR_LEN;
    nonfrag   = ~mf_r && (off_r == 13'd0);
    id_adv    = ~malformed && ~mtu_small && ~df_r && nonfrag;
    rem       = tot_r - IP4_HDR_LEN;
    room      = $signed({2'b00, mtu_r}) - 18'sd20 - $signed({8'd0, hoff_r});
    fits      = (rem == 16'd0) || (~room[17] && ({2'b00, rem} <= room[17:0]));
    room_small = room[17] || (room[16:3] == 14'd0);
    chunk     = fits ? rem : {room[15:3], 3'b000};
    limit     = {{FW{1'b0}}, chunk} * (16 + FW)'(MAX_FRAGMENTS);
    too_many  = ~fits && ({{FW{1'b0}}, rem} > limit);

    q_job.id        = nonfrag ? (next_id_r + 16'd1) : id_in_r;
    q_job.base_off  = off_r;
    q_job.base_more = mf_r;
    q_job.rem       = rem;
    q_job.chunk     = chunk;
    q_job.hoff      = hoff_r;
    q_job.kind      = kind_r;
    if (malformed) begin
      q_job.err = ERR_MALFORMED;
    end else if (mtu_small) begin
      q_job.err = ERR_HEADER;
    end else if (df_r) begin
      q_job.err = ERR_DONT_FRAG;
    end else if (~fits && room_small) begin
      q_job.err = ERR_HEADER;
    end else if (too_many) begin
      q_job.err = ERR_TOO_MANY;
    end else begin
      q_job.err = ERR_NONE;
    end

    item_valid_nxt = in_accept | (item_valid_r & ~q_push);
    next_id_nxt    = (q_push && id_adv) ? (next_id_r + 16'd1) : next_id_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      next_id_r    <= 16'd0;
    end else begin
      item_valid_r <= item_valid_nxt;
      next_id_r    <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tot_r   <= in_ip_total_length;
      capt_r  <= in_captured_length;
      hoff_r  <= in_header_offset;
      mtu_r   <= in_mtu;
      df_r    <= in_dont_fragment;
      mf_r    <= in_more_fragments_in;
      off_r   <= in_fragment_offset_in;
      id_in_r <= in_ident;
      kind_r  <= in_encap_kind;
    end
  end

endmodule

// ----- hdl/ipv4fp_queue.sv -----
// ----------------------------------------------------------------------------
// ipv4fp_queue
// Short job queue between the front end and the fragment sequencer.
// ----------------------------------------------------------------------------
module ipv4fp_queue #(
  parameter int DEPTH = ipv4fp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ipv4fp_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output ipv4fp_pkg::job_t head_job,
  output logic             empty
);
  import ipv4fp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue read while empty");

endmodule

// ----- hdl/ipv4fp_back.sv -----
// ----------------------------------------------------------------------------
// ipv4fp_back
// Walks one planned packet, producing one fragment request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ipv4fp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  ipv4fp_pkg::job_t q_job,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_error_code,
  output logic [15:0]      out_ident,
  output logic [12:0]      out_fragment_offset,
  output logic             out_more_fragments,
  output logic [15:0]      out_fragment_total_length,
  output logic [15:0]      out_payload_start,
  output logic [15:0]      out_slice_len,
  output logic [15:0]      out_outer_length,
  output logic             out_last
);
  import ipv4fp_pkg::*;

  logic        busy_r, busy_nxt;
  logic        out_valid_r, out_valid_nxt;
  job_t        job_r;
  logic [15:0] rem_r, ptr_r;

  logic        emit, is_err, is_last;
  logic [15:0] len;
  logic [16:0] frame, frame6;
  logic [15:0] outer;

  always_comb begin
    is_err  = (job_r.err != ERR_NONE);
    is_last = is_err || (rem_r <= job_r.chunk);
    len     = (rem_r > job_r.chunk) ? job_r.chunk : rem_r;
    frame   = {7'd0, job_r.hoff} + {1'b0, len} + {1'b0, IP4_HDR_LEN};
    frame6  = frame - IP6_HDR_LEN;
    case (job_r.kind)
      ENCAP_IPV4: outer = frame[15:0];
      ENCAP_IPV6: outer = frame6[15:0];
      default:    outer = 16'd0;
    endcase
    emit          = busy_r && (!out_valid_r || !out_stall);
    q_pop         = !q_empty && (!busy_r || (emit && is_last));
    busy_nxt      = q_pop || (busy_r && !(emit && is_last));
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      rem_r <= q_job.rem;
      ptr_r <= 16'd0;
    end else if (emit) begin
      rem_r <= rem_r - len;
      ptr_r <= ptr_r + len;
    end
    if (emit) begin
      out_error_code <= job_r.err;
      out_last       <= is_last;
      if (is_err) begin
        out_ident                 <= 16'd0;
        out_fragment_offset       <= 13'd0;
        out_more_fragments        <= 1'b0;
        out_fragment_total_length <= 16'd0;
        out_payload_start         <= 16'd0;
        out_slice_len             <= 16'd0;
        out_outer_length          <= 16'd0;
      end else begin
        out_ident                 <= job_r.id;
        out_fragment_offset       <= job_r.base_off + ptr_r[15:3];
        out_more_fragments        <= !is_last || job_r.base_more;
        out_fragment_total_length <= len + IP4_HDR_LEN;
        out_payload_start         <= ptr_r;
        out_slice_len             <= len;
        out_outer_length          <= outer;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE) |-> out_last)
    else $error("error request not marked last");

  a_mid_has_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> out_more_fragments)
    else $error("non-final fragment without More Fragments");

endmodule

// ----- hdl/ipv4_fragment_planner_core.sv -----
// A packet request goes from the front-end register through the job queue and the sequencer's
// job register into the output register. Fragments come out one per cycle while out_stall is low;
// error and single-fragment packets give one result each, so one packet per cycle is sustained.
// The fragment sequencer, walking the payload one slice per cycle unless stalled, sets the rate.
// Reset (rst_n, synchronous, low) empties all stages and clears the id counter to zero.
// ----------------------------------------------------------------------------
// ipv4_fragment_planner_core
// Plans the IPv4 fragmentation of one packet per request: a front end holds
// and checks the request, a two-entry job queue decouples it from the
// sequencer, and the sequencer emits one fragment request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ipv4_fragment_planner_core #(
  parameter int MAX_FRAGMENTS = ipv4fp_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_ip_total_length,
  input  logic [15:0] in_captured_length,
  input  logic [9:0]  in_header_offset,
  input  logic [15:0] in_mtu,
  input  logic        in_dont_fragment,
  input  logic        in_more_fragments_in,
  input  logic [12:0] in_fragment_offset_in,
  input  logic [15:0] in_ident,
  input  logic [1:0]  in_encap_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_ident,
  output logic [12:0] out_fragment_offset,
  output logic        out_more_fragments,
  output logic [15:0] out_fragment_total_length,
  output logic [15:0] out_payload_start,
  output logic [15:0] out_slice_len,
  output logic [15:0] out_outer_length,
  output logic        out_last
);
  import ipv4fp_pkg::*;

  // Job handoff between the front end and the sequencer.
  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, head_job;

  // The front end registers one request, classifies it (malformed, small
  // MTU, Don't Fragment, too little room, too many fragments) and computes
  // the per-fragment slice size. The fragment-count limit is checked as
  // remaining payload against slice size times the limit, with no divider.
  ipv4fp_front #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_ip_total_length   (in_ip_total_length),
    .in_captured_length   (in_captured_length),
    .in_header_offset     (in_header_offset),
    .in_mtu               (in_mtu),
    .in_dont_fragment     (in_dont_fragment),
    .in_more_fragments_in (in_more_fragments_in),
    .in_fragment_offset_in(in_fragment_offset_in),
    .in_ident             (in_ident),
    .in_encap_kind        (in_encap_kind),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_job                (push_job)
  );

  // The queue lets the front end keep accepting while the sequencer is
  // busy walking a long packet or the output is stalled.
  ipv4fp_queue #(
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .head_job(head_job),
    .empty   (q_empty)
  );

  // The sequencer emits one fragment per cycle into its output register while out_stall is low, and
  // picks up the next job in the same cycle that it emits the final one.
  ipv4fp_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_empty                  (q_empty),
    .q_job                    (head_job),
    .q_pop                    (q_pop),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_error_code           (out_error_code),
    .out_ident                (out_ident),
    .out_fragment_offset      (out_fragment_offset),
    .out_more_fragments       (out_more_fragments),
    .out_fragment_total_length(out_fragment_total_length),
    .out_payload_start        (out_payload_start),
    .out_slice_len            (out_slice_len),
    .out_outer_length         (out_outer_length),
    .out_last                 (out_last)
  );

endmodule

// ----- dv/ipv4_fragment_planner_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_fragment_planner_core_checker
// Watches both channels of the fragment planner, plans every accepted packet
// request on its own and compares each result field by field in order.
// ----------------------------------------------------------------------------
module ipv4_fragment_planner_core_checker #(
  parameter int MAX_FRAGMENTS = ipv4fp_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_ip_total_length,
  input  logic [15:0] in_captured_length,
  input  logic [9:0]  in_header_offset,
  input  logic [15:0] in_mtu,
  input  logic        in_dont_fragment,
  input  logic        in_more_fragments_in,
  input  logic [12:0] in_fragment_offset_in,
  input  logic [15:0] in_ident,
  input  logic [1:0]  in_encap_kind,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_error_code,
  input  logic [15:0] out_ident,
  input  logic [12:0] out_fragment_offset,
  input  logic        out_more_fragments,
  input  logic [15:0] out_fragment_total_length,
  input  logic [15:0] out_payload_start,
  input  logic [15:0] out_slice_len,
  input  logic [15:0] out_outer_length,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          requests_seen,
  output int          results_seen,
  output int          error_results
);
  import ipv4fp_pkg::*;

  localparam int IP4_BYTES = int'(IP4_HDR_LEN);
  localparam int IP6_BYTES = int'(IP6_HDR_LEN);

  typedef struct packed {
    logic [2:0]  err;
    logic [15:0] id;
    logic [12:0] offset;
    logic        more;
    logic [15:0] total;
    logic [15:0] start;
    logic [15:0] plen;
    logic [15:0] outer;
    logic        last;
  } fragment_t;

  fragment_t   planned_fragments[$];
  fragment_t   want;
  logic [15:0] id_counter = '0;

  function automatic void push_error(input logic [2:0] code);
    fragment_t f;
    f      = '0;
    f.err  = code;
    f.last = 1'b1;
    planned_fragments.push_back(f);
  endfunction

  // Plans one packet and appends its fragments, or its single error result.
  function automatic void plan_fragments(
    input logic [15:0] total,
    input logic [15:0] capt,
    input logic [9:0]  hoff,
    input logic [15:0] mtu,
    input logic        df,
    input logic        mf,
    input logic [12:0] off_in,
    input logic [15:0] id_in,
    input logic [1:0]  kind
  );
    fragment_t   f;
    logic [15:0] id;
    logic [12:0] base_off;
    logic        base_more;
    int          rem, room, chunk, nfrag, ptr, len, frame;
    if (total < IP4_HDR_LEN || capt < IP4_HDR_LEN || total < capt) begin
      push_error(ERR_MALFORMED);
      return;
    end
    if (mtu < IP4_HDR_LEN) begin
      push_error(ERR_HEADER);
      return;
    end
    if (df) begin
      push_error(ERR_DONT_FRAG);
      return;
    end
    // Only whole packets draw a fresh id; the counter moves even if a
    // later check rejects the packet.
    if (mf || off_in != '0) begin
      id        = id_in;
      base_off  = off_in;
      base_more = mf;
    end else begin
      id_counter = id_counter + 16'd1;
      id         = id_counter;
      base_off   = '0;
      base_more  = 1'b0;
    end
    rem  = int'(total) - IP4_BYTES;
    room = int'(mtu) - IP4_BYTES - int'(hoff);
    if (rem == 0 || rem <= room) begin
      chunk = rem;
      nfrag = 1;
    end else begin
      if (room < 8) begin
        push_error(ERR_HEADER);
        return;
      end
      chunk = room & ~7;
      nfrag = (rem + chunk - 1) / chunk;
      if (nfrag > MAX_FRAGMENTS) begin
        push_error(ERR_TOO_MANY);
        return;
      end
    end
    ptr = 0;
    for (int k = 0; k < nfrag; k++) begin
      len      = (rem > chunk) ? chunk : rem;
      frame    = int'(hoff) + len + IP4_BYTES;
      f.err    = ERR_NONE;
      f.id     = id;
      f.offset = 13'(int'(base_off) + (ptr >> 3));
      f.more   = (len != rem) || base_more;
      f.total  = 16'(len + IP4_BYTES);
      f.start  = 16'(ptr);
      f.plen   = 16'(len);
      case (kind)
        ENCAP_IPV4: f.outer = 16'(frame);
        ENCAP_IPV6: f.outer = 16'(frame - IP6_BYTES);
        default:    f.outer = '0;
      endcase
      f.last = (k == nfrag - 1);
      planned_fragments.push_back(f);
      rem = rem - len;
      ptr = ptr + len;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      planned_fragments.delete();
      id_counter = '0;
    end else begin
      if (in_valid && !in_stall) begin
        requests_seen++;
        plan_fragments(in_ip_total_length, in_captured_length, in_header_offset, in_mtu,
                       in_dont_fragment, in_more_fragments_in, in_fragment_offset_in,
                       in_ident, in_encap_kind);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_error_code != ERR_NONE) error_results++;
        if (planned_fragments.size() == 0) begin
          $display("%0t ns: result with none expected, actual error %0d id %0d payload %0d",
                   $time, out_error_code, out_ident, out_slice_len);
          fail_count++;
        end else begin
          want = planned_fragments.pop_front();
          check_field("error_code", want.err, out_error_code);
          check_field("ident", want.id, out_ident);
          check_field("fragment_offset", want.offset, out_fragment_offset);
          check_field("more_fragments", want.more, out_more_fragments);
          check_field("fragment_total_length", want.total, out_fragment_total_length);
          check_field("payload_start", want.start, out_payload_start);
          check_field("slice_len", want.plen, out_slice_len);
          check_field("outer_length", want.outer, out_outer_length);
          check_field("last", want.last, out_last);
        end
      end
    end
    pending = planned_fragments.size();
  end

endmodule

// ----- dv/ipv4_fragment_planner_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_fragment_planner_core_tb
// Drives packet requests into the fragment planner, a directed set of corner
// packets first and then a long random mix, while the result side stalls at
// random. A checker beside the block plans and compares every result.
// ----------------------------------------------------------------------------
module ipv4_fragment_planner_core_tb;
  import ipv4fp_pkg::*;

  // Encapsulation code with no meaning; the block must treat it as none.
  localparam logic [1:0] ENCAP_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 500;
  // The result side holds off once for this many cycles after this many
  // results have gone through, long enough to back the block up to its input.
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_TRIGGER    = 200;
  // Extra cycles to wait after the last expected result; the pipeline runs through the front
  // end, the job queue and the sequencer, so this covers anything still in flight.
  localparam int SETTLE_CYCLES   = 10;
  // Longest correct stretch without any handshake is the long hold above,
  // so a few times that is a safe bound for a hang.
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic [15:0] total;
    logic [15:0] capt;
    logic [9:0]  hoff;
    logic [15:0] mtu;
    logic        df;
    logic        mf;
    logic [12:0] off;
    logic [15:0] id;
    logic [1:0]  kind;
  } packet_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_ip_total_length;
  logic [15:0] in_captured_length;
  logic [9:0]  in_header_offset;
  logic [15:0] in_mtu;
  logic        in_dont_fragment;
  logic        in_more_fragments_in;
  logic [12:0] in_fragment_offset_in;
  logic [15:0] in_ident;
  logic [1:0]  in_encap_kind;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_error_code;
  logic [15:0] out_ident;
  logic [12:0] out_fragment_offset;
  logic        out_more_fragments;
  logic [15:0] out_fragment_total_length;
  logic [15:0] out_payload_start;
  logic [15:0] out_slice_len;
  logic [15:0] out_outer_length;
  logic        out_last;

  int fail_count;
  int pending;
  int requests_seen;
  int results_seen;
  int error_results;

  ipv4_fragment_planner_core u_top (.*);

  ipv4_fragment_planner_core_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int gap_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic packet_req_t packet(
    input int unsigned total, input int unsigned capt, input int unsigned hoff,
    input int unsigned mtu, input bit df, input bit mf, input int unsigned off,
    input int unsigned id, input logic [1:0] kind
  );
    packet_req_t r;
    r.total = 16'(total);
    r.capt  = 16'(capt);
    r.hoff  = 10'(hoff);
    r.mtu   = 16'(mtu);
    r.df    = df;
    r.mf    = mf;
    r.off   = 13'(off);
    r.id    = 16'(id);
    r.kind  = kind;
    return r;
  endfunction

  // Most requests are well-formed packets sized to a chosen fragment count,
  // so the sequencer is kept busy; the rest hit each error path or are noise.
  function automatic packet_req_t random_request();
    packet_req_t r;
    int unsigned sel, room, chunk, nfrag, rem;
    sel    = $urandom_range(99);
    r.hoff = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(60));
    r.kind = ($urandom_range(15) == 0) ? ENCAP_UNUSED : 2'($urandom_range(2));
    r.df   = 1'b0;
    if ($urandom_range(1) == 0) begin
      r.mf  = 1'b0;
      r.off = '0;
    end else begin
      r.mf  = 1'($urandom);
      r.off = 13'($urandom);
    end
    r.id  = 16'($urandom);
    room  = ($urandom_range(3) == 0) ? $urandom_range(8, 9000) : $urandom_range(8, 1500);
    nfrag = ($urandom_range(9) == 0) ? $urandom_range(5, 64) : $urandom_range(1, 4);
    if (room + 20 + r.hoff > 65535) room = 65535 - 20 - r.hoff;
    chunk = room & ~32'd7;
    if (nfrag == 1) rem = $urandom_range(0, room);
    else rem = $urandom_range(chunk * (nfrag - 1) + 1, chunk * nfrag);
    if (rem > 65515) rem = 65515;
    r.mtu   = 16'(room + 20 + r.hoff);
    r.total = 16'(rem + 20);
    r.capt  = 16'($urandom_range(20, rem + 20));
    if (sel >= 60 && sel < 70) begin
      // Malformed in one of its three ways.
      case ($urandom_range(2))
        0: r.total = 16'($urandom_range(19));
        1: r.capt = 16'($urandom_range(19));
        default: begin
          r.total = 16'($urandom_range(20, 65534));
          r.capt  = 16'($urandom_range(int'(r.total) + 1, 65535));
        end
      endcase
    end else if (sel >= 70 && sel < 75) begin
      r.mtu = 16'($urandom_range(19));
    end else if (sel >= 75 && sel < 80) begin
      r.df = 1'b1;
    end else if (sel >= 80 && sel < 86) begin
      // Payload room below one 8-byte unit, or negative, with payload to split.
      r.mtu   = 16'($urandom_range(20, 27 + r.hoff));
      r.total = 16'($urandom_range(28, 65535));
      r.capt  = 16'($urandom_range(20, r.total));
    end else if (sel >= 86 && sel < 92) begin
      // Small slices and a long payload: more fragments than the block allows.
      r.mtu   = 16'(20 + r.hoff + $urandom_range(8, 64));
      r.total = 16'($urandom_range(4700, 65535));
      r.capt  = 16'($urandom_range(20, r.total));
    end else if (sel >= 92) begin
      r = packet_req_t'($bits(packet_req_t)'({$urandom, $urandom, $urandom, $urandom}));
    end
    return r;
  endfunction

  // Presents one request at a falling edge and holds it until it is taken.
  task automatic send_request(input packet_req_t r);
    @(negedge clk);
    in_ip_total_length    <= r.total;
    in_captured_length    <= r.capt;
    in_header_offset      <= r.hoff;
    in_mtu                <= r.mtu;
    in_dont_fragment      <= r.df;
    in_more_fragments_in  <= r.mf;
    in_fragment_offset_in <= r.off;
    in_ident              <= r.id;
    in_encap_kind         <= r.kind;
    in_valid              <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stops offering requests until every planned fragment has come out.
  task automatic drain_results();
    idle_sender(1);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random stalls, stretches with none at all, and one long
  // hold once enough results have passed, each counted here per cycle.
  int stall_left = 0;
  int run_left   = 0;
  bit hold_done  = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_TRIGGER) begin
      hold_done  = 1'b1;
      stall_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else begin
      run_left   = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 4);
      stall_left = gap_length();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // A hang on either channel ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no request moved on either side for %0d cycles, %0d results due",
                 quiet_cycles, pending);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_ip_total_length    = '0;
    in_captured_length    = '0;
    in_header_offset      = '0;
    in_mtu                = '0;
    in_dont_fragment      = 1'b0;
    in_more_fragments_in  = 1'b0;
    in_fragment_offset_in = '0;
    in_ident              = '0;
    in_encap_kind         = ENCAP_NONE;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners. Empty payload with the smallest legal MTU.
    send_request(packet(20, 20, 0, 20, 0, 0, 0, 0, ENCAP_NONE));
    // The three kinds of malformed packet.
    send_request(packet(19, 19, 0, 1500, 0, 0, 0, 0, ENCAP_NONE));
    send_request(packet(100, 19, 0, 1500, 0, 0, 0, 0, ENCAP_NONE));
    send_request(packet(100, 101, 0, 1500, 0, 0, 0, 0, ENCAP_NONE));
    // MTU one byte short of a bare header.
    send_request(packet(100, 100, 0, 19, 0, 0, 0, 0, ENCAP_NONE));
    idle_sender(gap_length());
    // Don't Fragment rejects even a packet that fits.
    send_request(packet(100, 100, 0, 1500, 1, 0, 0, 0, ENCAP_NONE));
    // Payload exactly fills the room, then a typical split with an outer IPv6.
    send_request(packet(1500, 1500, 0, 1500, 0, 0, 0, 0, ENCAP_IPV4));
    send_request(packet(4000, 1200, 14, 1500, 0, 0, 0, 0, ENCAP_IPV6));
    // Room below eight bytes, and room made negative by a big encapsulation.
    // Both still consume an id, which the next whole packet shows.
    send_request(packet(100, 100, 0, 27, 0, 0, 0, 0, ENCAP_NONE));
    send_request(packet(200, 200, 1023, 100, 0, 0, 0, 0, ENCAP_IPV4));
    idle_sender(gap_length());
    // Far too many fragments, exactly the maximum, and one over it.
    send_request(packet(65535, 65535, 0, 28, 0, 0, 0, 0, ENCAP_NONE));
    send_request(packet(532, 532, 0, 28, 0, 0, 0, 0, ENCAP_IPV4));
    send_request(packet(540, 540, 0, 28, 0, 0, 0, 0, ENCAP_NONE));
    // Already a fragment: the offset wraps past 8191 and the id is kept.
    send_request(packet(3000, 3000, 0, 1000, 0, 1, 8191, 16'hFFFF, ENCAP_IPV6));
    send_request(packet(600, 600, 20, 300, 0, 0, 100, 16'h1234, ENCAP_NONE));
    // Unused encapsulation code, and an outer IPv6 length that wraps below zero.
    send_request(packet(200, 150, 20, 1500, 0, 0, 0, 0, ENCAP_UNUSED));
    send_request(packet(20, 20, 0, 20, 0, 0, 0, 0, ENCAP_IPV6));
    idle_sender(gap_length());
    // Widest fields: a two-way split, an exact fit and a refused fragment.
    send_request(packet(65535, 65535, 1023, 65535, 0, 0, 0, 0, ENCAP_IPV4));
    send_request(packet(65535, 65535, 0, 65535, 0, 0, 0, 0, ENCAP_IPV6));
    send_request(packet(65535, 65535, 1023, 65535, 1, 1, 8191, 16'hFFFF, ENCAP_UNUSED));
    // Many small slices behind the largest encapsulation.
    send_request(packet(1000, 1000, 1023, 1063, 0, 0, 0, 0, ENCAP_IPV4));
    // One unit of room: an exact fit, then a one-byte tail fragment.
    send_request(packet(28, 20, 0, 28, 0, 0, 0, 0, ENCAP_NONE));
    send_request(packet(29, 29, 0, 28, 0, 0, 0, 0, ENCAP_IPV6));
    drain_results();

    // Random mix. A stretch in the middle runs without sender gaps, and at
    // the halfway point the sender waits for the block to empty.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) drain_results();
      send_request(random_request());
      if (i < 60 || i >= 120) idle_sender(gap_length());
    end
    drain_results();

    $display("Covered %0d packet requests and %0d result items, %0d of them error results,",
             requests_seen, results_seen, error_results);
    $display("with directed corners, random stalls and a %0d-cycle output hold.", LONG_HOLD);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
